@@ hw/rtl/dmxr_pkg.sv @@
// Shared types and constants for the DMX fixture look renderer.
// Used by dmxr_ctrl, dmxr_dp and the top level; depends on nothing.
package dmxr_pkg;
   localparam logic [1:0] CMD_RENDER = 2'd0;
   localparam logic [1:0] CMD_RAW    = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [2:0] REG_START = 3'd0;
   localparam logic [2:0] REG_MODE  = 3'd1;
   localparam logic [2:0] REG_CMIN  = 3'd2;
   localparam logic [2:0] REG_CMAX  = 3'd3;
   localparam logic [2:0] REG_ODIM  = 3'd4;
   localparam logic [2:0] REG_OCCT  = 3'd5;
   localparam logic [2:0] REG_OHUE  = 3'd6;
   localparam logic [2:0] REG_OSAT  = 3'd7;

   localparam logic [7:0] SEL_CCT = 8'd16;
   localparam logic [7:0] SEL_HSI = 8'd48;
   localparam logic [7:0] SEL_FX  = 8'd80;
   localparam logic [7:0] OFFSET_UNUSED = 8'd255;

   localparam int DIV_STEPS = 26;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming word
      logic div_start; // load the CCT divider
      logic div_step;  // one restoring step
      logic put;       // write the current entry
      logic rd;        // read the addressed slot
      logic done;      // drive the response
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic       clearing;  // store clearing pass after reset
      logic [3:0] n_entries;
      logic       is_read;
      logic       is_render;
   } stat_type;
endpackage

@@ hw/rtl/dmxr_ctrl.sv @@
// Sequencer for the look renderer: capture, divide, serial slot writes, slot reads.
// Depends on dmxr_pkg.
module dmxr_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  dmxr_pkg::stat_type stat,
   output dmxr_pkg::cmd_type  cmd,
   output logic [3:0] entry
);
   import dmxr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_DEC = 6'b000010, S_DIV = 6'b000100,
      S_PUT = 6'b001000, S_READ = 6'b010000, S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [3:0] ent_ff, ent_in;

   assign busy  = (state_ff != S_IDLE) || stat.clearing;
   assign entry = ent_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ent_in = ent_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && !stat.clearing) begin
               cmd.capture = 1'b1;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            ent_in = '0;
            if (stat.is_render) begin
               cmd.div_start = 1'b1;
               cnt_in = 5'(DIV_STEPS - 1);
               state_in = S_DIV;
            end else if (stat.is_read) begin
               cmd.rd = 1'b1;
               state_in = S_READ;
            end else
               state_in = S_PUT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) state_in = S_PUT;
         end
         S_PUT: begin
            if (ent_ff < stat.n_entries) begin
               cmd.put = 1'b1;
               ent_in = ent_ff + 4'd1;
            end else
               state_in = S_DONE;
         end
         S_READ: state_in = S_DONE;
         S_DONE: begin
            cmd.done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         ent_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ent_ff <= ent_in;
      end
   end
endmodule

@@ hw/rtl/dmxr_dp.sv @@
// Datapath: config registers, byte scaling, CCT divider, universe store.
// Depends on dmxr_pkg.
module dmxr_dp #(
   parameter int UNIVERSE_SLOTS = 512,
   parameter int EFFECT_PARAM_COUNT = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   input  logic [2:0] csr_index,
   input  logic [14:0] csr_data,
   input  dmxr_pkg::cmd_type cmd,
   input  logic [3:0] entry,
   output dmxr_pkg::stat_type stat,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_slot,
   input  logic [7:0]  req_raw_value,
   input  logic [15:0] req_intensity,
   input  logic [14:0] req_colour_temp_kelvin,
   input  logic signed [9:0] req_green_magenta,
   input  logic [11:0] req_hue_tenths,
   input  logic [15:0] req_saturation,
   input  logic req_use_effect,
   input  logic req_use_hsi,
   input  logic [7:0]  req_effect_number,
   input  logic [47:0] req_effect_params,
   output logic rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_slots_written
);
   import dmxr_pkg::*;

   localparam int SW = $clog2(UNIVERSE_SLOTS + 1);
   localparam int ENT = 3 + EFFECT_PARAM_COUNT;

   // config
   logic [9:0] start_ff; logic [1:0] mode_ff;
   logic [14:0] cmin_ff, cmax_ff;
   logic [7:0] odim_ff, occt_ff, ohue_ff, osat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 10'd1; mode_ff <= 2'd0;
         cmin_ff <= 15'd2700; cmax_ff <= 15'd6500;
         odim_ff <= 8'd0; occt_ff <= 8'd1; ohue_ff <= 8'd255; osat_ff <= 8'd255;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_START: start_ff <= csr_data[9:0];
            REG_MODE:  mode_ff  <= csr_data[1:0];
            REG_CMIN:  cmin_ff  <= csr_data;
            REG_CMAX:  cmax_ff  <= csr_data;
            REG_ODIM:  odim_ff  <= csr_data[7:0];
            REG_OCCT:  occt_ff  <= csr_data[7:0];
            REG_OHUE:  ohue_ff  <= csr_data[7:0];
            REG_OSAT:  osat_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // captured word
   logic [1:0] c_cmd_ff; logic [9:0] c_slot_ff; logic [7:0] c_raw_ff;
   logic [15:0] c_int_ff, c_sat_ff; logic [14:0] c_k_ff;
   logic signed [9:0] c_gm_ff; logic [11:0] c_hue_ff;
   logic c_fx_ff, c_hsi_ff; logic [7:0] c_fxn_ff; logic [47:0] c_par_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         c_cmd_ff <= req_cmd; c_slot_ff <= req_slot; c_raw_ff <= req_raw_value;
         c_int_ff <= req_intensity; c_sat_ff <= req_saturation;
         c_k_ff <= req_colour_temp_kelvin; c_gm_ff <= req_green_magenta;
         c_hue_ff <= req_hue_tenths; c_fx_ff <= req_use_effect;
         c_hsi_ff <= req_use_hsi; c_fxn_ff <= req_effect_number;
         c_par_ff <= req_effect_params;
      end
   end

   // constant-divisor scaling by reciprocal multiplication, rounded half up
   function automatic logic [7:0] clamp8(input logic [9:0] q);
      clamp8 = (q > 10'd255) ? 8'd255 : q[7:0];
   endfunction

   // dim, sat: round(x*255/65535) = floor((x+128)/257)
   logic [16:0] dim_m, sat_m;
   logic [33:0] dim_p, sat_p;
   // hue: round(h*255/3600) = floor(((51h+360)>>4)/45)
   logic [17:0] hue_m;
   logic [31:0] hue_p;
   // gm: round(g*255/1000) = floor(((51g+100)>>3)/25)
   logic [10:0] gm_s;
   logic [15:0] gm_m;
   logic [27:0] gm_p;
   logic [7:0] dim_b, sat_b, hue_b, gm_b;
   assign dim_m = 17'(c_int_ff) + 17'd128;
   assign sat_m = 17'(c_sat_ff) + 17'd128;
   assign dim_p = 34'(dim_m) * 34'd65281;
   assign sat_p = 34'(sat_m) * 34'd65281;
   assign dim_b = clamp8(dim_p[33:24]);
   assign sat_b = clamp8(sat_p[33:24]);
   assign hue_m = 18'(c_hue_ff) * 18'd51 + 18'd360;
   assign hue_p = 32'(hue_m[17:4]) * 32'd23302;
   assign hue_b = clamp8(hue_p[29:20]);
   assign gm_s = 11'($signed({c_gm_ff[9], c_gm_ff}) + 11'sd500);
   assign gm_m = 16'(gm_s[9:0]) * 16'd51 + 16'd100;
   assign gm_p = 28'(gm_m[15:3]) * 28'd10486;
   assign gm_b = (gm_s[10] || gm_s == '0) ? 8'd0 : clamp8(gm_p[27:18]);

   // CCT restoring divider: q = (2*num + span) / (2*span), 26 steps
   logic [25:0] dnum_ff, dq_ff; logic [26:0] drem_ff; logic [25:0] dden_ff;
   logic cct_ok_ff;
   logic [14:0] span, kdiff;
   assign span = cmax_ff - cmin_ff;
   assign kdiff = c_k_ff - cmin_ff;
   logic [26:0] trial;
   assign trial = {drem_ff[25:0], dnum_ff[25]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dnum_ff <= 26'(kdiff) * 26'd510 + 26'(span);
         dden_ff <= {10'd0, span, 1'b0};
         drem_ff <= '0; dq_ff <= '0;
         cct_ok_ff <= (cmax_ff > cmin_ff) && (c_k_ff > cmin_ff);
      end else if (cmd.div_step) begin
         dnum_ff <= {dnum_ff[24:0], 1'b0};
         if (trial >= {1'b0, dden_ff}) begin
            drem_ff <= trial - {1'b0, dden_ff};
            dq_ff <= {dq_ff[24:0], 1'b1};
         end else begin
            drem_ff <= trial;
            dq_ff <= {dq_ff[24:0], 1'b0};
         end
      end
   end
   logic [7:0] cct_b;
   assign cct_b = !cct_ok_ff ? 8'd0 : (dq_ff > 26'd255 ? 8'd255 : dq_ff[7:0]);

   // entry table for the current word
   logic [7:0] e_off; logic [7:0] e_val; logic [3:0] n_ent;
   always_comb begin
      e_off = OFFSET_UNUSED; e_val = '0; n_ent = '0;
      if (c_cmd_ff == CMD_RAW) begin
         n_ent = 4'd1;
      end else if (c_cmd_ff == CMD_RENDER) begin
         unique case (mode_ff)
            2'd0: begin
               e_off = {4'd0, entry};
               if (c_fx_ff) begin
                  n_ent = 4'(ENT);
                  priority case (entry)
                     4'd0: e_val = SEL_FX;
                     4'd1: e_val = dim_b;
                     4'd2: e_val = c_fxn_ff;
                     default: e_val = (entry - 4'd3 < 4'd6) ?
                        c_par_ff[(6'(entry - 4'd3) * 6'd8) +: 8] : 8'd0;
                  endcase
               end else begin
                  n_ent = 4'd4;
                  unique case (entry[1:0])
                     2'd0: e_val = c_hsi_ff ? SEL_HSI : SEL_CCT;
                     2'd1: e_val = dim_b;
                     2'd2: e_val = c_hsi_ff ? hue_b : cct_b;
                     default: e_val = c_hsi_ff ? sat_b : gm_b;
                  endcase
               end
            end
            2'd1: begin
               n_ent = 4'd2;
               e_off = {4'd0, entry};
               e_val = entry[0] ? cct_b : dim_b;
            end
            2'd2: begin
               n_ent = c_hsi_ff ? 4'd4 : 4'd2;
               unique case (entry[1:0])
                  2'd0: begin e_off = odim_ff; e_val = dim_b; end
                  2'd1: begin e_off = occt_ff; e_val = cct_b; end
                  2'd2: begin e_off = ohue_ff; e_val = hue_b; end
                  default: begin e_off = osat_ff; e_val = sat_b; end
               endcase
            end
            default: n_ent = '0;
         endcase
      end
   end

   assign stat.n_entries = n_ent;
   assign stat.is_read = (c_cmd_ff == CMD_READ);
   assign stat.is_render = (c_cmd_ff == CMD_RENDER);

   logic [10:0] w_slot; logic [7:0] w_data; logic w_ok;
   always_comb begin
      if (c_cmd_ff == CMD_RAW) begin
         w_slot = {1'b0, c_slot_ff}; w_data = c_raw_ff; w_ok = 1'b1;
      end else begin
         w_slot = 11'(start_ff) + 11'(e_off); w_data = e_val;
         w_ok = (e_off != OFFSET_UNUSED);
      end
      w_ok = w_ok && (w_slot >= 11'd1) && (w_slot <= 11'(UNIVERSE_SLOTS));
   end

   // clearing pass after reset: zero one slot per cycle, slot 0 first
   logic clr_ff;
   logic [SW-1:0] clr_addr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1; clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + SW'(1);
         if (clr_addr_ff == SW'(UNIVERSE_SLOTS)) clr_ff <= 1'b0;
      end
   end
   assign stat.clearing = clr_ff;

   // universe store
   logic [7:0] mem [0:UNIVERSE_SLOTS];
   logic [7:0] rdat_ff;
   logic [3:0] wcnt_ff;
   always_ff @(posedge clock) begin
      if (clr_ff) mem[clr_addr_ff] <= '0;
      else if (cmd.put && w_ok) mem[w_slot[SW-1:0]] <= w_data;
      if (cmd.rd) rdat_ff <= mem[c_slot_ff[SW-1:0]];
   end
   logic rd_ok_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         wcnt_ff <= '0; rd_ok_ff <= 1'b0;
      end else begin
         if (cmd.capture) wcnt_ff <= '0;
         else if (cmd.put && w_ok) wcnt_ff <= wcnt_ff + 4'd1;
         if (cmd.rd)
            rd_ok_ff <= (11'(c_slot_ff) <= 11'(UNIVERSE_SLOTS));
      end
   end

   assign rsp_valid = cmd.done;
   assign rsp_read_data = (stat.is_read && rd_ok_ff) ? rdat_ff : 8'd0;
   assign rsp_slots_written = wcnt_ff;
endmodule

@@ hw/rtl/dmx_fixture_look_renderer.sv @@
// DMX fixture look renderer, top level.
// Depends on dmxr_pkg, dmxr_ctrl and dmxr_dp.
//
// Usage:
//  - Command channel: drive req_* and pulse start while busy is low; the
//    word is taken at that edge. busy stays high until the response.
//  - Response: rsp_valid is high for one cycle with rsp_read_data and
//    rsp_slots_written. The receiver cannot stall; take it when shown.
//  - Config: csr_valid/csr_ready with csr_index and csr_data; ready is
//    always high. Write only while idle.
//  - Sequence: a read goes through decode, read and response; raw
//    write and unknown command through the slot-write state; a render
//    runs 26 restoring-divider steps for the CCT quotient, then one
//    write step per profile slot (0 to 9 slots), then the response.
//  - One word at a time; the next is taken only once busy is low.
//  - Reset: registers take their defaults, then busy holds high for a
//    clearing pass that zeroes every slot of the store.
module dmx_fixture_look_renderer #(
   parameter int UNIVERSE_SLOTS = 512,
   parameter int EFFECT_PARAM_COUNT = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0]  req_cmd,
   input  logic [9:0]  req_slot,
   input  logic [7:0]  req_raw_value,
   input  logic [15:0] req_intensity,
   input  logic [14:0] req_colour_temp_kelvin,
   input  logic signed [9:0] req_green_magenta,
   input  logic [11:0] req_hue_tenths,
   input  logic [15:0] req_saturation,
   input  logic req_use_effect,
   input  logic req_use_hsi,
   input  logic [7:0]  req_effect_number,
   input  logic [47:0] req_effect_params,
   output logic rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_slots_written,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [14:0] csr_data
);
   import dmxr_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic [3:0] entry;

   // accept config words at any time
   assign csr_ready = 1'b1;

   dmxr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd), .entry(entry)
   );

   dmxr_dp #(.UNIVERSE_SLOTS(UNIVERSE_SLOTS),
             .EFFECT_PARAM_COUNT(EFFECT_PARAM_COUNT)) u_dp (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .cmd(cmd), .entry(entry), .stat(stat),
      .req_cmd(req_cmd), .req_slot(req_slot), .req_raw_value(req_raw_value),
      .req_intensity(req_intensity),
      .req_colour_temp_kelvin(req_colour_temp_kelvin),
      .req_green_magenta(req_green_magenta), .req_hue_tenths(req_hue_tenths),
      .req_saturation(req_saturation), .req_use_effect(req_use_effect),
      .req_use_hsi(req_use_hsi), .req_effect_number(req_effect_number),
      .req_effect_params(req_effect_params),
      .rsp_valid(rsp_valid), .rsp_read_data(rsp_read_data),
      .rsp_slots_written(rsp_slots_written)
   );
endmodule

@@ tb/tb.sv @@
// Self-checking bench for dmx_fixture_look_renderer: directed table, edge settings, then random words.
// Depends on dmxr_pkg and the renderer RTL; predicts every response in place.
`timescale 1ns / 100ps

module tb;
   import dmxr_pkg::*;

   localparam int NSLOTS = 512;
   localparam int LIMIT_CYCLES = 400000;

   logic clock, reset, start, busy;
   logic [1:0]  req_cmd;
   logic [9:0]  req_slot;
   logic [7:0]  req_raw_value;
   logic [15:0] req_intensity;
   logic [14:0] req_colour_temp_kelvin;
   logic signed [9:0] req_green_magenta;
   logic [11:0] req_hue_tenths;
   logic [15:0] req_saturation;
   logic req_use_effect, req_use_hsi;
   logic [7:0]  req_effect_number;
   logic [47:0] req_effect_params;
   logic rsp_valid;
   logic [7:0] rsp_read_data;
   logic [3:0] rsp_slots_written;
   logic csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [14:0] csr_data;

   dmx_fixture_look_renderer DUT (.*);

   // one command word as the bench sees it
   typedef struct {
      logic [1:0]  cmd;
      logic [9:0]  slot;
      logic [7:0]  raw;
      logic [15:0] inten;
      logic [14:0] kelvin;
      logic [9:0]  gm;
      logic [11:0] hue;
      logic [15:0] sat;
      logic        fx;
      logic        hsi;
      logic [7:0]  fx_num;
      logic [47:0] fx_par;
   } look_word_type;

   typedef struct {
      logic [7:0] rd;
      logic [3:0] nw;
   } slot_resp_type;

   // shadow universe and shadow registers
   logic [7:0]  shadow_universe [0:NSLOTS];
   logic [9:0]  sh_start;
   logic [1:0]  sh_mode;
   logic [14:0] sh_cmin, sh_cmax;
   logic [7:0]  sh_odim, sh_octt, sh_ohue, sh_osat;

   slot_resp_type pending_resp[$];
   int errors = 0;
   int cycles = 0;
   int words_sent = 0;
   int resp_seen = 0;
   int send_idle_pct = 0;
   logic [3:0] put_count;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // timeout guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [7:0] round_byte(longint unsigned num, longint unsigned den);
      longint unsigned q;
      q = (2 * num + den) / (2 * den);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // write one profile slot into the shadow, drop when unused or out of range
   task automatic put_shadow(input int unsigned offset, input logic [7:0] val);
      int unsigned s;
      if (offset == OFFSET_UNUSED) return;
      s = sh_start + offset;
      if (s >= 1 && s <= NSLOTS) begin
         shadow_universe[s] = val;
         put_count++;
      end
   endtask

   // predict the response of one word and update the shadow universe
   task automatic predict_look(input look_word_type w, output slot_resp_type r);
      logic [7:0] dim, cct, gmb, hueb, satb;
      int gmv;
      r.rd = 0;
      put_count = 0;
      case (w.cmd)
         CMD_RENDER: begin
            dim  = round_byte(w.inten * 255, 65535);
            satb = round_byte(w.sat * 255, 65535);
            hueb = round_byte(w.hue * 255, 3600);
            gmv  = $signed(w.gm) + 500;
            gmb  = (gmv > 0) ? round_byte(gmv * 255, 1000) : 8'd0;
            cct  = 0;
            if (sh_cmax > sh_cmin && w.kelvin > sh_cmin)
               cct = round_byte((w.kelvin - sh_cmin) * 255, sh_cmax - sh_cmin);
            case (sh_mode)
               2'd0: begin
                  if (w.fx) begin
                     put_shadow(0, SEL_FX);
                     put_shadow(1, dim);
                     put_shadow(2, w.fx_num);
                     for (int i = 0; i < 6; i++) put_shadow(3 + i, w.fx_par[8*i +: 8]);
                  end else if (w.hsi) begin
                     put_shadow(0, SEL_HSI);
                     put_shadow(1, dim);
                     put_shadow(2, hueb);
                     put_shadow(3, satb);
                  end else begin
                     put_shadow(0, SEL_CCT);
                     put_shadow(1, dim);
                     put_shadow(2, cct);
                     put_shadow(3, gmb);
                  end
               end
               2'd1: begin
                  put_shadow(0, dim);
                  put_shadow(1, cct);
               end
               2'd2: begin
                  put_shadow(sh_odim, dim);
                  put_shadow(sh_octt, cct);
                  if (w.hsi) begin
                     put_shadow(sh_ohue, hueb);
                     put_shadow(sh_osat, satb);
                  end
               end
               default: ;
            endcase
         end
         CMD_RAW: begin
            if (w.slot >= 1 && w.slot <= NSLOTS) begin
               shadow_universe[w.slot] = w.raw;
               put_count = 1;
            end
         end
         CMD_READ: if (w.slot <= NSLOTS) r.rd = shadow_universe[w.slot];
         default: ;
      endcase
      r.nw = put_count;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // response checker: the receiver never stalls, so every strobe is taken
   always @(posedge clock) begin
      slot_resp_type want;
      if (!reset && rsp_valid) begin
         resp_seen++;
         if (pending_resp.size() == 0) begin
            report_mismatch("unexpected response", rsp_slots_written, -1);
         end else begin
            want = pending_resp.pop_front();
            if (rsp_read_data !== want.rd) report_mismatch("read_data", rsp_read_data, want.rd);
            if (rsp_slots_written !== want.nw)
               report_mismatch("slots_written", rsp_slots_written, want.nw);
         end
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [14:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_START: sh_start = val[9:0];
         REG_MODE:  sh_mode  = val[1:0];
         REG_CMIN:  sh_cmin  = val;
         REG_CMAX:  sh_cmax  = val;
         REG_ODIM:  sh_odim  = val[7:0];
         REG_OCCT:  sh_octt  = val[7:0];
         REG_OHUE:  sh_ohue  = val[7:0];
         REG_OSAT:  sh_osat  = val[7:0];
      endcase
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // hold the word on the ports until the block takes it; drop start after
   task automatic send_word(input look_word_type w, input bit typed,
                            input slot_resp_type typed_resp);
      slot_resp_type r;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clock);
      req_cmd <= w.cmd;  req_slot <= w.slot;  req_raw_value <= w.raw;
      req_intensity <= w.inten;  req_colour_temp_kelvin <= w.kelvin;
      req_green_magenta <= w.gm;  req_hue_tenths <= w.hue;  req_saturation <= w.sat;
      req_use_effect <= w.fx;  req_use_hsi <= w.hsi;
      req_effect_number <= w.fx_num;  req_effect_params <= w.fx_par;
      start <= 1;
      do @(posedge clock); while (busy);
      predict_look(w, r);
      // typed-in rows must also agree with the shadow; keep the typed value
      if (typed) begin
         if (r.rd !== typed_resp.rd || r.nw !== typed_resp.nw)
            report_mismatch("table row vs shadow", r.nw, typed_resp.nw);
         r = typed_resp;
      end
      pending_resp.push_back(r);
      words_sent++;
      start <= 0;
      // the block is busy now; advance one edge so start drops cleanly
      @(posedge clock);
   endtask

   // wait until every response is in, then let the block settle
   task automatic drain;
      while (pending_resp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic look_word_type blank_word(input logic [1:0] c, input logic [9:0] s,
                                               input logic [7:0] v);
      look_word_type w;
      w = '{default: '0};
      w.cmd = c; w.slot = s; w.raw = v;
      return w;
   endfunction

   function automatic look_word_type random_word;
      look_word_type w;
      int k;
      k = $urandom_range(99);
      w.cmd   = (k < 50) ? CMD_RENDER : (k < 72) ? CMD_RAW : (k < 97) ? CMD_READ : 2'd3;
      w.slot  = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(NSLOTS));
      w.raw   = 8'($urandom);
      w.inten = 16'($urandom);
      w.kelvin = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(20000));
      w.gm    = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1000) - 500);
      w.hue   = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(3600));
      w.sat   = 16'($urandom);
      w.fx    = 1'($urandom);
      w.hsi   = 1'($urandom);
      w.fx_num = 8'($urandom);
      w.fx_par = 48'({$urandom, $urandom});
      return w;
   endfunction

   task automatic random_setting;
      write_reg(REG_START, ($urandom_range(7) == 0) ? 15'($urandom_range(1023))
                                                    : 15'($urandom_range(1, NSLOTS)));
      write_reg(REG_MODE, 15'($urandom_range(3)));
      write_reg(REG_CMIN, 15'($urandom_range(1000, 20000)));
      write_reg(REG_CMAX, 15'($urandom_range(1000, 20000)));
      write_reg(REG_ODIM, ($urandom_range(4) == 0) ? 15'd255 : 15'($urandom_range(20)));
      write_reg(REG_OCCT, ($urandom_range(4) == 0) ? 15'd255 : 15'($urandom_range(20)));
      write_reg(REG_OHUE, ($urandom_range(4) == 0) ? 15'd255 : 15'($urandom_range(255)));
      write_reg(REG_OSAT, ($urandom_range(4) == 0) ? 15'd255 : 15'($urandom_range(255)));
   endtask

   typedef struct {
      look_word_type w;
      bit            typed;
      slot_resp_type r;
   } table_row_type;

   initial begin
      table_row_type rows[$];
      look_word_type w;
      slot_resp_type none;
      int idle_plan [4] = '{0, 45, 0, 11};

      // drive every input known from time zero
      reset = 1; start = 0; csr_valid = 0; csr_index = 0; csr_data = 0;
      req_cmd = 0; req_slot = 0; req_raw_value = 0; req_intensity = 0;
      req_colour_temp_kelvin = 0; req_green_magenta = 0; req_hue_tenths = 0;
      req_saturation = 0; req_use_effect = 0; req_use_hsi = 0;
      req_effect_number = 0; req_effect_params = 0;
      for (int i = 0; i <= NSLOTS; i++) shadow_universe[i] = 0;
      sh_start = 1; sh_mode = 0; sh_cmin = 2700; sh_cmax = 6500;
      sh_odim = 0; sh_octt = 1; sh_ohue = 255; sh_osat = 255;
      none = '{0, 0};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed table: reset reads, raw extremes, every profile
      rows.push_back('{blank_word(CMD_READ, 0, 0), 1, '{0, 0}});
      rows.push_back('{blank_word(CMD_READ, 512, 0), 1, '{0, 0}});
      rows.push_back('{blank_word(CMD_RAW, 1, 8'hFF), 1, '{0, 1}});
      rows.push_back('{blank_word(CMD_READ, 1, 0), 1, '{8'hFF, 0}});
      rows.push_back('{blank_word(CMD_RAW, 512, 8'hA5), 1, '{0, 1}});
      rows.push_back('{blank_word(CMD_READ, 512, 0), 1, '{8'hA5, 0}});
      rows.push_back('{blank_word(CMD_RAW, 0, 8'h11), 1, '{0, 0}});
      rows.push_back('{blank_word(CMD_RAW, 513, 8'h11), 1, '{0, 0}});
      rows.push_back('{blank_word(CMD_RAW, 1023, 8'h11), 1, '{0, 0}});
      rows.push_back('{blank_word(CMD_READ, 0, 0), 1, '{0, 0}});
      rows.push_back('{blank_word(CMD_READ, 1023, 0), 1, '{0, 0}});
      rows.push_back('{blank_word(2'd3, 5, 8'h22), 1, '{0, 0}});
      // CCT profile, all fields at zero then full; then the HSI and effect profiles
      w = blank_word(CMD_RENDER, 0, 0);
      rows.push_back('{w, 1, '{0, 4}});
      w.inten = 16'hFFFF; w.kelvin = 15'h7FFF; w.gm = 10'sd500; w.hue = 12'hFFF;
      w.sat = 16'hFFFF;
      rows.push_back('{w, 0, none});
      w.gm = 10'h200; rows.push_back('{w, 0, none});
      w.hsi = 1; rows.push_back('{w, 0, none});
      w.fx = 1; w.fx_num = 8'hFF; w.fx_par = '1; rows.push_back('{w, 1, '{0, 9}});
      w.fx_par = 48'h0605_0403_0201; w.inten = 16'd128; rows.push_back('{w, 0, none});
      for (int i = 1; i <= 5; i++) rows.push_back('{blank_word(CMD_READ, i, 0), 0, none});
      rows.push_back('{blank_word(CMD_READ, 9, 0), 0, none});

      foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].r);
      drain();

      // edge settings: fixture at the top of the universe, empty span, custom, mode 3
      write_reg(REG_START, 512);
      w = random_word(); w.cmd = CMD_RENDER; w.fx = 1;
      send_word(w, 1, '{0, 1});
      drain();
      write_reg(REG_CMIN, 20000); write_reg(REG_CMAX, 1000);
      write_reg(REG_START, 1); write_reg(REG_MODE, 1);
      w.fx = 0; send_word(w, 0, none);
      drain();
      write_reg(REG_MODE, 2);
      write_reg(REG_ODIM, 255); write_reg(REG_OCCT, 255);
      write_reg(REG_OHUE, 0); write_reg(REG_OSAT, 255);
      w.hsi = 1; send_word(w, 0, none);
      drain();
      write_reg(REG_MODE, 3);
      send_word(w, 1, '{0, 0});
      drain();
      write_reg(REG_CMIN, 1000); write_reg(REG_CMAX, 20000);
      write_reg(REG_MODE, 0);
      send_word(w, 0, none);
      drain();

      // random phases; each block of words runs under a fresh register setting
      for (int ph = 0; ph < 30; ph++) begin
         send_idle_pct = idle_plan[ph % 4];
         if (ph % 4 == 0) begin
            write_reg(REG_MODE, 0); write_reg(REG_START, 15'($urandom_range(1, NSLOTS)));
            write_reg(REG_CMIN, 2700); write_reg(REG_CMAX, 6500);
         end else random_setting();
         for (int n = 0; n < 50; n++) send_word(random_word(), 0, none);
         drain();
      end

      $display("tb: %0d words sent, %0d responses checked", words_sent, resp_seen);
      $display("tb: covered raw/read extremes, all profiles and random register settings");
      if (errors == 0 && pending_resp.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
